@@ rtl/psdr_pkg.sv @@
// ----------------------------------------------------------------------------
// psdr_pkg
// Types and byte codes shared by the PS/2 device responder modules.
// ----------------------------------------------------------------------------
package psdr_pkg;

  localparam int unsigned MaxRun = 7;
  localparam int unsigned CntW   = 3;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    ReqHost    = 2'd0,
    ReqPress   = 2'd1,
    ReqRelease = 2'd2,
    ReqUnused  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ArgNone  = 2'd0,
    ArgKbd   = 2'd1,
    ArgSet   = 2'd2,
    ArgMouse = 2'd3
  } arg_e;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;  // byte 0 goes out first
    logic [CntW-1:0]        count;
  } run_t;

  // host commands
  localparam byte_t CmdSetLeds     = 8'hED;
  localparam byte_t CmdSetRate     = 8'hF3;
  localparam byte_t CmdScanSet     = 8'hF0;
  localparam byte_t CmdReadId      = 8'hF2;
  localparam byte_t CmdEnable      = 8'hF4;
  localparam byte_t CmdDisable     = 8'hF5;
  localparam byte_t CmdDefaults    = 8'hF6;
  localparam byte_t CmdReset       = 8'hFF;
  localparam byte_t CmdSetRes      = 8'hE8;
  localparam byte_t CmdStatus      = 8'hE9;
  localparam byte_t CmdReadData    = 8'hEB;
  localparam byte_t CmdScale11     = 8'hE6;
  localparam byte_t CmdScale21     = 8'hE7;
  localparam byte_t CmdStream      = 8'hEA;
  localparam byte_t CmdResetWrap   = 8'hEC;
  localparam byte_t CmdWrap        = 8'hEE;
  localparam byte_t CmdRemote      = 8'hF0;

  // device replies
  localparam byte_t RspAck         = 8'hFA;
  localparam byte_t RspSelfTest    = 8'hAA;
  localparam byte_t RspKbdId0      = 8'hAB;
  localparam byte_t RspKbdId1      = 8'h83;
  localparam byte_t RspScanSet2    = 8'h02;
  localparam byte_t RspZero        = 8'h00;
  localparam byte_t RspMseStat1    = 8'h02;
  localparam byte_t RspMseStat2    = 8'h64;
  localparam byte_t RspMseData0    = 8'h08;

  // scan code prefixes and modifier keys
  localparam byte_t PfxExt         = 8'hE0;
  localparam byte_t PfxBreak       = 8'hF0;
  localparam byte_t KeyLShift      = 8'h12;
  localparam byte_t KeyLCtrl       = 8'h14;

endpackage

@@ rtl/psdr_decode.sv @@
// ----------------------------------------------------------------------------
// psdr_decode
// Turns one request into its reply run and the next argument mark.
// ----------------------------------------------------------------------------
module psdr_decode
  import psdr_pkg::*;
(
  input  logic [1:0] req_type_i,
  input  logic [7:0] host_byte_i,
  input  logic [7:0] key_code_i,
  input  logic       key_extended_i,
  input  logic       with_shift_i,
  input  logic       with_ctrl_i,
  input  logic       device_kind_i,
  input  arg_e       arg_i,
  output run_t       run_o,
  output arg_e       arg_o
);

  logic [MaxRun-1:0][7:0] bytes;
  logic [CntW-1:0]        n;

  always_comb begin
    bytes = '0;
    n     = '0;
    arg_o = arg_i;
    unique case (req_e'(req_type_i))
      ReqHost: begin
        if (arg_i != ArgNone) begin
          // argument byte: ack whatever value arrives
          arg_o = ArgNone;
          bytes[0] = RspAck;
          n = CntW'(1);
          if (arg_i == ArgSet && host_byte_i == RspZero) begin
            bytes[1] = RspScanSet2;
            n = CntW'(2);
          end
        end else if (!device_kind_i) begin
          unique case (host_byte_i) inside
            CmdSetLeds, CmdSetRate: begin
              bytes[0] = RspAck; n = CntW'(1); arg_o = ArgKbd;
            end
            CmdScanSet: begin
              bytes[0] = RspAck; n = CntW'(1); arg_o = ArgSet;
            end
            CmdReadId: begin
              bytes[0] = RspAck; bytes[1] = RspKbdId0; bytes[2] = RspKbdId1;
              n = CntW'(3);
            end
            CmdEnable, CmdDisable, CmdDefaults: begin
              bytes[0] = RspAck; n = CntW'(1);
            end
            CmdReset: begin
              bytes[0] = RspSelfTest; n = CntW'(1);
            end
            default: ;
          endcase
        end else begin
          unique case (host_byte_i) inside
            CmdSetRes, CmdSetRate: begin
              bytes[0] = RspAck; n = CntW'(1); arg_o = ArgMouse;
            end
            CmdStatus: begin
              bytes[0] = RspAck; bytes[1] = RspZero;
              bytes[2] = RspMseStat1; bytes[3] = RspMseStat2;
              n = CntW'(4);
            end
            CmdReadData: begin
              bytes[0] = RspAck; bytes[1] = RspMseData0;
              bytes[2] = RspZero; bytes[3] = RspZero;
              n = CntW'(4);
            end
            CmdReadId: begin
              bytes[0] = RspAck; bytes[1] = RspZero; n = CntW'(2);
            end
            CmdReset: begin
              bytes[0] = RspAck; bytes[1] = RspSelfTest; bytes[2] = RspZero;
              n = CntW'(3);
            end
            CmdScale11, CmdScale21, CmdStream, CmdResetWrap, CmdWrap,
            CmdRemote, CmdEnable, CmdDisable, CmdDefaults: begin
              bytes[0] = RspAck; n = CntW'(1);
            end
            default: ;
          endcase
        end
      end
      ReqPress: begin
        if (with_shift_i) begin
          bytes[n] = KeyLShift; n = n + CntW'(1);
        end
        if (with_ctrl_i) begin
          bytes[n] = KeyLCtrl; n = n + CntW'(1);
        end
        if (key_extended_i) begin
          bytes[n] = PfxExt; n = n + CntW'(1);
        end
        bytes[n] = key_code_i;
        n = n + CntW'(1);
      end
      ReqRelease: begin
        if (key_extended_i) begin
          bytes[n] = PfxExt; n = n + CntW'(1);
        end
        bytes[n] = PfxBreak;
        n = n + CntW'(1);
        bytes[n] = key_code_i;
        n = n + CntW'(1);
        if (with_shift_i) begin
          bytes[n] = PfxBreak; n = n + CntW'(1);
          bytes[n] = KeyLShift; n = n + CntW'(1);
        end
        if (with_ctrl_i) begin
          bytes[n] = PfxBreak; n = n + CntW'(1);
          bytes[n] = KeyLCtrl; n = n + CntW'(1);
        end
      end
      default: ;
    endcase
    run_o.bytes = bytes;
    run_o.count = n;
  end

endmodule

@@ rtl/psdr_txq.sv @@
// ----------------------------------------------------------------------------
// psdr_txq
// Result register: holds one reply run and hands it out a byte per transfer.
// ----------------------------------------------------------------------------
module psdr_txq
  import psdr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  run_t       run_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o
);

  logic [MaxRun-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   xfer;

  assign out_valid_o = (count_q != '0);
  assign xfer        = out_valid_o && !out_stall_i;
  assign last_byte_o = (count_q == CntW'(1));
  assign tx_byte_o   = bytes_q[0];
  assign free_o      = !out_valid_o || (xfer && last_byte_o);

  always_comb begin
    bytes_d = bytes_q;
    count_d = count_q;
    if (load_i) begin
      bytes_d = run_i.bytes;
      count_d = run_i.count;
    end else if (xfer) begin
      // advance to the next byte of the run
      bytes_d = bytes_q >> 8;
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

@@ rtl/ps2_device_responder_top.sv @@
// ----------------------------------------------------------------------------
// ps2_device_responder_top
// Device end of a PS/2 link, keyboard or mouse, replying to host bytes and
// key events with runs of device bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request per transfer:
//   a host byte, a key press or a key release. Output channel
//   (out_valid_o / out_stall_i) gives one reply byte per transfer, with
//   last_byte_o set on the final byte of each run. Requests with no reply
//   (unknown command, unused type) give no output transfer.
//   cfg_we_i writes device_kind (0 keyboard, 1 mouse) from cfg_wdata_i;
//   write it only while the block is idle.
//   A request goes to the input register, then its run to the result
//   register that drives the output. A run of 1 to 7 bytes leaves at one
//   byte per cycle while out_stall_i is low; the output port paces input.
//   The input register takes the next request while the result register
//   still drains the previous run.
//   Reset clears the argument mark, selects keyboard and empties both
//   registers. When the receiver stalls, the current byte holds and the
//   input side stalls once the input register is full.
// ----------------------------------------------------------------------------
module ps2_device_responder_top
  import psdr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] host_byte_i,
  input  logic [7:0] key_code_i,
  input  logic       key_extended_i,
  input  logic       with_shift_i,
  input  logic       with_ctrl_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o
);

  logic       kind_q;
  arg_e       arg_q, arg_d;
  logic       a_valid_q, a_valid_d;
  logic [1:0] req_q;
  logic [7:0] host_q;
  logic [7:0] code_q;
  logic       ext_q;
  logic       shift_q;
  logic       ctrl_q;

  run_t       dec_run;
  logic       txq_free;
  logic       advance;
  logic       accept;

  psdr_decode u_decode (
    .req_type_i     (req_q),
    .host_byte_i    (host_q),
    .key_code_i     (code_q),
    .key_extended_i (ext_q),
    .with_shift_i   (shift_q),
    .with_ctrl_i    (ctrl_q),
    .device_kind_i  (kind_q),
    .arg_i          (arg_q),
    .run_o          (dec_run),
    .arg_o          (arg_d)
  );

  // move the held request on when it has no reply or the run slot frees up
  assign advance    = a_valid_q && ((dec_run.count == '0) || txq_free);
  assign in_stall_o = a_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (advance) begin
      a_valid_d = 1'b0;
    end
  end

  psdr_txq u_txq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (dec_run.count != '0)),
    .run_i       (dec_run),
    .free_o      (txq_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= 1'b0;
      arg_q     <= ArgNone;
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      if (cfg_we_i) begin
        kind_q <= cfg_wdata_i;
      end
      if (advance) begin
        arg_q <= arg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      host_q  <= host_byte_i;
      code_q  <= key_code_i;
      ext_q   <= key_extended_i;
      shift_q <= with_shift_i;
      ctrl_q  <= with_ctrl_i;
    end
  end

endmodule
